>>> design/srrw_pkg.sv
`timescale 1ns / 1ps

package srrw_pkg;

    localparam int WINDOW = 32;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int RUN_W  = $clog2(WINDOW + 1);
    localparam int SEQ_W  = 31;
    localparam int ACK_W  = 32;
    localparam int NACK_W = 64;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 7;
    localparam int FBI_W  = 7;
    localparam int REPLY_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 144;

    localparam logic [FBI_W-1:0] FBI_RESET = 7'd8;

    typedef enum logic [1:0] {
        REQ_SESSION = 2'd0,
        REQ_DATA    = 2'd1,
        REQ_FINAL   = 2'd2,
        REQ_IGNORE  = 2'd3
    } req_type_t;

    localparam logic [REPLY_W-1:0] REPLY_NONE   = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_ACCEPT = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_BUSY   = 2'd2;

    typedef struct packed {
        req_type_t          req_type;
        logic [SEQ_W-1:0]   seq_num;
    } item_t;

    typedef struct packed {
        logic               busy;
        logic [SEQ_W-1:0]   base;
        logic [IDX_W-1:0]   base_slot;
        logic [WINDOW-1:0]  bitmap;
        logic [CNT_W-1:0]   pkt_cnt;
        logic               final_known;
        logic [SEQ_W-1:0]   final_seq;
    } state_t;

    typedef struct packed {
        logic [REPLY_W-1:0] session_reply;
        logic               store_enable;
        logic [SLOT_W-1:0]  store_slot;
        logic [CNT_W-1:0]   deliver_count;
        logic [SEQ_W-1:0]   deliver_first_seq;
        logic               feedback_valid;
        logic [ACK_W-1:0]   cumulative_ack;
        logic [NACK_W-1:0]  nack_mask;
        logic               done_valid;
    } result_t;

endpackage

>>> design/srrw_window_logic.sv
`timescale 1ns / 1ps

module srrw_window_logic (
    input  srrw_pkg::item_t               item,
    input  srrw_pkg::state_t              st,
    input  logic [srrw_pkg::FBI_W-1:0]    fb_interval,
    output srrw_pkg::state_t              nxt,
    output srrw_pkg::result_t             res
);

    logic [srrw_pkg::SEQ_W-1:0]   diff;
    logic                         in_win;
    logic [srrw_pkg::IDX_W-1:0]   idx;
    logic                         is_new;
    logic [srrw_pkg::WINDOW-1:0]  marked;
    logic [srrw_pkg::WINDOW-1:0]  shifted;
    logic [srrw_pkg::WINDOW-1:0]  nack_w;
    logic [srrw_pkg::RUN_W-1:0]   run;
    logic [srrw_pkg::RUN_W-1:0]   span;
    logic [srrw_pkg::SEQ_W-1:0]   new_base;
    logic [srrw_pkg::SEQ_W-1:0]   span_full;
    logic [srrw_pkg::SEQ_W-1:0]   fin_seq;
    logic                         fin_known;
    logic                         is_data;
    logic                         is_final;
    logic                         periodic;
    logic                         done;
    logic                         fb;
    logic [srrw_pkg::CNT_W-1:0]   cnt_inc;
    logic [srrw_pkg::IDX_W:0]     slot_sum;
    logic [srrw_pkg::IDX_W:0]     base_slot_sum;
    logic [srrw_pkg::IDX_W-1:0]   slot;
    logic [srrw_pkg::IDX_W-1:0]   new_slot;

    // mark, then slide over the received run at the base
    always_comb begin
        is_data  = (item.req_type == srrw_pkg::REQ_DATA);
        is_final = (item.req_type == srrw_pkg::REQ_FINAL);

        diff   = item.seq_num - st.base;
        in_win = (item.seq_num >= st.base) &&
                 (diff < srrw_pkg::SEQ_W'(srrw_pkg::WINDOW));
        idx    = diff[srrw_pkg::IDX_W-1:0];
        is_new = in_win && !st.bitmap[idx];

        marked = st.bitmap;
        if (is_new) begin
            marked[idx] = 1'b1;
        end

        slot_sum = {1'b0, st.base_slot} + (srrw_pkg::IDX_W+1)'(idx);
        if (slot_sum >= (srrw_pkg::IDX_W+1)'(srrw_pkg::WINDOW)) begin
            slot = srrw_pkg::IDX_W'(slot_sum - (srrw_pkg::IDX_W+1)'(srrw_pkg::WINDOW));
        end else begin
            slot = slot_sum[srrw_pkg::IDX_W-1:0];
        end

        run = srrw_pkg::RUN_W'(srrw_pkg::WINDOW);
        for (int i = srrw_pkg::WINDOW - 1; i >= 0; i--) begin
            if (!marked[i]) begin
                run = srrw_pkg::RUN_W'(i);
            end
        end

        shifted  = marked >> run;
        new_base = st.base + srrw_pkg::SEQ_W'(run);

        base_slot_sum = {1'b0, st.base_slot} + (srrw_pkg::IDX_W+1)'(run);
        if (base_slot_sum >= (srrw_pkg::IDX_W+1)'(srrw_pkg::WINDOW)) begin
            new_slot = srrw_pkg::IDX_W'(base_slot_sum -
                                        (srrw_pkg::IDX_W+1)'(srrw_pkg::WINDOW));
        end else begin
            new_slot = base_slot_sum[srrw_pkg::IDX_W-1:0];
        end

        cnt_inc  = st.pkt_cnt + srrw_pkg::CNT_W'(1);
        periodic = is_data && (cnt_inc >= fb_interval);

        fin_known = st.final_known || is_final;
        fin_seq   = is_final ? item.seq_num : st.final_seq;
        done      = fin_known && (new_base == fin_seq + srrw_pkg::SEQ_W'(1));
        fb        = !done && (periodic || is_final);

        // nack span clamped to the window
        span_full = item.seq_num - new_base;
        if (item.seq_num > new_base) begin
            if (span_full >= srrw_pkg::SEQ_W'(srrw_pkg::WINDOW)) begin
                span = srrw_pkg::RUN_W'(srrw_pkg::WINDOW);
            end else begin
                span = span_full[srrw_pkg::RUN_W-1:0];
            end
        end else begin
            span = '0;
        end

        for (int i = 0; i < srrw_pkg::WINDOW; i++) begin
            nack_w[i] = !shifted[i] && (srrw_pkg::RUN_W'(i) < span);
        end
    end

    always_comb begin
        nxt = st;
        res = '0;
        unique case (item.req_type)
            srrw_pkg::REQ_SESSION: begin
                if (st.busy) begin
                    res.session_reply = srrw_pkg::REPLY_BUSY;
                end else begin
                    res.session_reply = srrw_pkg::REPLY_ACCEPT;
                    nxt             = '0;
                    nxt.busy        = 1'b1;
                end
            end
            srrw_pkg::REQ_DATA, srrw_pkg::REQ_FINAL: begin
                res.store_enable = is_new;
                res.store_slot   = is_new ? srrw_pkg::SLOT_W'(slot) : '0;
                res.deliver_count = srrw_pkg::CNT_W'(run);
                res.deliver_first_seq = (run != '0) ? st.base : '0;

                nxt.base        = new_base;
                nxt.base_slot   = new_slot;
                nxt.bitmap      = shifted;
                nxt.final_known = fin_known;
                nxt.final_seq   = fin_seq;
                if (periodic) begin
                    nxt.pkt_cnt = '0;
                end else if (is_data) begin
                    nxt.pkt_cnt = cnt_inc;
                end

                if (done) begin
                    res.done_valid     = 1'b1;
                    res.cumulative_ack = {1'b0, fin_seq};
                    nxt                = '0;
                end else if (fb) begin
                    res.feedback_valid = 1'b1;
                    res.cumulative_ack = {1'b0, new_base} - srrw_pkg::ACK_W'(1);
                    res.nack_mask      = srrw_pkg::NACK_W'(nack_w);
                end
            end
            srrw_pkg::REQ_IGNORE: begin
                nxt = st;
            end
            default: begin
                nxt = st;
            end
        endcase
    end

endmodule

>>> design/selective_repeat_receive_window.sv
`timescale 1ns / 1ps

// Channel | Dir | tdata                 | tuser        | tlast
// s_      | in  | seq_num[30:0]         | req_type[1:0]| -
// m_      | out | reply..nack_mask      | -            | done_valid
//
// One request per cycle sustained while m_tready is high. A request sits in
// the input register, then window mark, slide and feedback are resolved in
// one pass into the result register; window state updates at that same edge.
// s_tready stays high while the result register drains or is free.
// Synchronous active-low reset: window idle, base 0, interval 8.

module selective_repeat_receive_window (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [srrw_pkg::FBI_W-1:0]        cfg_wdata,     // feedback_interval
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [srrw_pkg::S_TDATA_W-1:0]    s_tdata,       // [30:0] seq_num
    input  logic [1:0]                        s_tuser,       // [1:0] req_type
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] session_reply, [2] store_enable, [8:3] store_slot,
    // [15:9] deliver_count, [46:16] deliver_first_seq, [47] feedback_valid,
    // [79:48] cumulative_ack, [143:80] nack_mask
    output logic [srrw_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast        // done_valid
);

    logic                        in_valid_reg;
    srrw_pkg::item_t             in_item_reg;
    srrw_pkg::state_t            state_reg;
    srrw_pkg::state_t            state_next;
    logic                        out_valid_reg;
    srrw_pkg::result_t           out_res_reg;
    srrw_pkg::result_t           res_next;
    logic [srrw_pkg::FBI_W-1:0]  fbi_reg;
    logic                        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    srrw_window_logic u_logic (
        .item        (in_item_reg),
        .st          (state_reg),
        .fb_interval (fbi_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fbi_reg <= srrw_pkg::FBI_RESET;
        end else if (cfg_we) begin
            fbi_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.req_type <= srrw_pkg::req_type_t'(s_tuser);
            in_item_reg.seq_num  <= s_tdata[srrw_pkg::SEQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.done_valid;
    assign m_tdata  = {out_res_reg.nack_mask,
                       out_res_reg.cumulative_ack,
                       out_res_reg.feedback_valid,
                       out_res_reg.deliver_first_seq,
                       out_res_reg.deliver_count,
                       out_res_reg.store_slot,
                       out_res_reg.store_enable,
                       out_res_reg.session_reply};

endmodule

>>> design/srrw_checker.sv
`timescale 1ns / 1ps

module srrw_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [srrw_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_done_no_feedback: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tdata[47] && (m_tdata[143:80] == 64'd0))
        else $error("done with feedback");

    a_slot_only_on_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> (m_tdata[8:3] == 6'd0))
        else $error("slot without store");

    a_deliver_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:9] <= 7'(srrw_pkg::WINDOW)) &&
                     ((m_tdata[15:9] != 7'd0) || (m_tdata[46:16] == 31'd0)))
        else $error("bad delivery report");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);
